// ===== hw/rtl/r2ca_pkg.sv =====
package r2ca_pkg;

  // Row geometry
  localparam int unsigned CellCount  = 512;
  localparam int unsigned LoadOffset = 64;
  localparam int unsigned IdxW       = $clog2(CellCount);
  localparam int unsigned PtrMax     = (CellCount > LoadOffset) ? CellCount : LoadOffset;
  localparam int unsigned PtrW       = $clog2(PtrMax + 1);

  // Rule window and configuration
  localparam int unsigned WinW     = 5;
  localparam int unsigned RuleW    = 32;
  localparam int unsigned GenW     = 8;
  localparam int unsigned GenReset = 20;
  localparam int unsigned CfgIdxW  = 1;

  // Result arithmetic: accumulator is wide enough for the full index sum
  localparam int unsigned SumW = 18;
  localparam int unsigned AccW = 2 * PtrW + 2;
  localparam logic signed [AccW-1:0] SumMax = AccW'((1 <<< (SumW - 1)) - 1);
  localparam logic signed [AccW-1:0] SumMin = AccW'(-(1 <<< (SumW - 1)));

  // Stream word widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RULE_TABLE  = 1'b0,
    CFG_GENERATIONS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;   // write the accepted cell, advance the load pointer
    logic check;  // sample the row ends, arm the counters
    logic gen;    // run one generation
    logic sum;    // fold one cell into the sum, shift the row
    logic push;   // move the sum into the output register, clear the run
  } cmd_t;

  typedef struct packed {
    logic gens_zero;
    logic gen_last;
    logic sum_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/radius2_cellular_automaton.sv =====
// Non-last words: accepted one per cycle while the block is loading, no result.
// Last word: result valid after the edge check, G generations one per cycle (none when G is 0),
// one cell per cycle through the index sum, and the output load once the output is free.
// The next run's words are accepted while the previous result waits on the output.
// Reset (rst_ni low, asynchronous): row empty, load pointer at LOAD_OFFSET, rule table 0,
// generations 20, no result pending.
module radius2_cellular_automaton (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [r2ca_pkg::InDataW-1:0]        s_axis_tdata,  // [0] cell_alive
  input  logic                                s_axis_tlast,  // last_cell
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [r2ca_pkg::OutDataW-1:0]       m_axis_tdata,  // [17:0] pot_sum
  output logic                                m_axis_tuser,  // [0] edge_overflow
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [r2ca_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [r2ca_pkg::RuleW-1:0]          cfg_data_i
);

  r2ca_pkg::cmd_t                   cmd;
  r2ca_pkg::sts_t                   sts;
  logic signed [r2ca_pkg::SumW-1:0] pot_sum;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // Sequencer: load, edge check, generations, summation, hand-off
  r2ca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Row register, rule lookup, counters, accumulator and output register
  r2ca_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cell_alive_i    (s_axis_tdata[0]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .pot_sum_o       (pot_sum),
    .edge_overflow_o (m_axis_tuser)
  );

  // Pad the signed sum with zeros up to a whole byte
  assign m_axis_tdata = {{(r2ca_pkg::OutDataW - r2ca_pkg::SumW){1'b0}}, pot_sum};

endmodule

// ===== hw/rtl/r2ca_ctrl.sv =====
module r2ca_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  r2ca_pkg::sts_t sts_i,
  output r2ca_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_GEN   = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.load = in_fire;
        if (in_fire && in_last_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.gens_zero ? ST_SUM : ST_GEN;
      end
      ST_GEN: begin
        cmd_o.gen = 1'b1;
        if (sts_i.gen_last) state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        if (sts_i.sum_last) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.push = sts_i.out_free;
        if (sts_i.out_free) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/r2ca_dp.sv =====
module r2ca_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [r2ca_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [r2ca_pkg::RuleW-1:0]         cfg_data_i,
  input  logic                               cell_alive_i,
  input  r2ca_pkg::cmd_t                     cmd_i,
  output r2ca_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [r2ca_pkg::SumW-1:0]   pot_sum_o,
  output logic                               edge_overflow_o
);

  localparam int unsigned N = r2ca_pkg::CellCount;

  logic [r2ca_pkg::RuleW-1:0] rule_q;
  logic [r2ca_pkg::GenW-1:0]  gens_q, gen_cnt_q, gen_cnt_d;
  logic [N-1:0]               row_q, row_d, row_next;
  logic [N+3:0]               row_pad;
  logic [r2ca_pkg::PtrW-1:0]  ptr_q, ptr_d;
  logic [r2ca_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                       edge_q, edge_d;
  logic signed [r2ca_pkg::AccW-1:0] acc_q, acc_d, term, sat;
  logic signed [r2ca_pkg::SumW-1:0] pot_sum_q;
  logic                       edge_out_q, out_valid_q, out_valid_d;
  logic                       ptr_room;

  // One generation over the whole row; cells beyond the ends read as empty
  assign row_pad = {2'b00, row_q, 2'b00};
  always_comb begin
    for (int i = 0; i < N; i++) begin
      row_next[i] = rule_q[{row_pad[i], row_pad[i+1], row_pad[i+2], row_pad[i+3], row_pad[i+4]}];
    end
  end

  assign ptr_room = (ptr_q < r2ca_pkg::PtrW'(N));
  assign term = signed'(r2ca_pkg::AccW'(idx_q)) - signed'(r2ca_pkg::AccW'(r2ca_pkg::LoadOffset));

  always_comb begin
    if (acc_q > r2ca_pkg::SumMax) begin
      sat = r2ca_pkg::SumMax;
    end else if (acc_q < r2ca_pkg::SumMin) begin
      sat = r2ca_pkg::SumMin;
    end else begin
      sat = acc_q;
    end
  end

  always_comb begin
    row_d       = row_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    edge_d      = edge_q;
    acc_d       = acc_q;
    gen_cnt_d   = gen_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load && ptr_room) begin
      for (int i = 0; i < N; i++) begin
        if (ptr_q == r2ca_pkg::PtrW'(i)) row_d[i] = cell_alive_i;
      end
      ptr_d = ptr_q + 1'b1;
    end
    if (cmd_i.check) begin
      edge_d    = edge_q | row_q[0] | row_q[N-1];
      gen_cnt_d = gens_q;
      idx_d     = '0;
      acc_d     = '0;
    end
    if (cmd_i.gen) begin
      row_d     = row_next;
      edge_d    = edge_q | row_next[0] | row_next[N-1];
      gen_cnt_d = gen_cnt_q - 1'b1;
    end
    // Shift zeros in from the top: the row is empty once the sum is done
    if (cmd_i.sum) begin
      if (row_q[0]) acc_d = acc_q + term;
      row_d = {1'b0, row_q[N-1:1]};
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
      ptr_d       = r2ca_pkg::PtrW'(r2ca_pkg::LoadOffset);
      edge_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q      <= '0;
      gens_q      <= r2ca_pkg::GenW'(r2ca_pkg::GenReset);
      row_q       <= '0;
      ptr_q       <= r2ca_pkg::PtrW'(r2ca_pkg::LoadOffset);
      idx_q       <= '0;
      edge_q      <= 1'b0;
      gen_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == r2ca_pkg::CFG_RULE_TABLE) rule_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == r2ca_pkg::CFG_GENERATIONS) begin
        gens_q <= cfg_data_i[r2ca_pkg::GenW-1:0];
      end
      row_q       <= row_d;
      ptr_q       <= ptr_d;
      idx_q       <= idx_d;
      edge_q      <= edge_d;
      gen_cnt_q   <= gen_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.push) begin
      pot_sum_q  <= sat[r2ca_pkg::SumW-1:0];
      edge_out_q <= edge_q;
    end
  end

  assign sts_o.gens_zero = (gens_q == '0);
  assign sts_o.gen_last  = (gen_cnt_q == r2ca_pkg::GenW'(1));
  assign sts_o.sum_last  = (idx_q == r2ca_pkg::IdxW'(N - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign pot_sum_o       = pot_sum_q;
  assign edge_overflow_o = edge_out_q;

endmodule

// ===== hw/rtl/r2ca_checker.sv =====
module r2ca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [r2ca_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Stop taking words for at least the edge check and one more step after a last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted during a run");

  // A new result appears only when input was blocked just before it rises
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised outside the hand-off step");

  // Padding bits above the sum stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[r2ca_pkg::OutDataW-1:r2ca_pkg::SumW] == '0)
    else $error("nonzero padding in result word");

endmodule

bind radius2_cellular_automaton r2ca_checker u_r2ca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
